@@ rtl/mpic_pkg.sv @@
// Package of the multiprocessor interrupt controller: request types, codes and helpers.
`timescale 1ns / 1ps

package mpic_pkg;

  localparam int unsigned NumCpusDef = 4;
  localparam int unsigned MaxCpus    = 16;
  localparam int unsigned PortLanes  = 4;

  localparam logic [15:0] LineMask = 16'hFFFE;

  localparam logic [1:0] ReqNone  = 2'd0;
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqWrite = 2'd2;

  localparam logic [1:0] PageCtrl  = 2'd0;
  localparam logic [1:0] PageMask  = 2'd1;
  localparam logic [1:0] PageForce = 2'd2;

  localparam logic [2:0] WordLevel  = 3'd0;
  localparam logic [2:0] WordPend   = 3'd1;
  localparam logic [2:0] WordForce0 = 3'd2;
  localparam logic [2:0] WordClear  = 3'd3;
  localparam logic [2:0] WordStatus = 3'd4;
  localparam logic [2:0] WordBcast  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  reg_addr;
    logic [31:0] write_data;
    logic [15:0] irq_lines;
    logic [3:0]  ack_valid;
    logic [15:0] ack_levels;
    logic [3:0]  power_down;
    logic        clear_all;
  } mpic_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] irq_levels;
    logic [3:0]  cpu_reset;
  } mpic_rsp_t;

  // Highest set line among 15..1, zero when none.
  function automatic logic [3:0] top_line(logic [15:0] v);
    logic [3:0] l;
    l = '0;
    for (int k = 1; k < 16; k++) begin
      if (v[k]) begin
        l = 4'(k);
      end
    end
    return l;
  endfunction

endpackage

@@ rtl/multiprocessor_interrupt_controller.sv @@
// Top level of the multiprocessor interrupt controller with registered request levels.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (mpic_req_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (mpic_rsp_t)
//
// One request per clock cycle when not stalled; the output register takes its response.
// All register updates and the per-CPU priority search finish in the accepting cycle.
// Reset clears every control register and the output valid.
// A stalled output holds its response; a new request is taken only if the output can move.
`timescale 1ns / 1ps

module multiprocessor_interrupt_controller
  import mpic_pkg::*;
#(
  parameter int unsigned CPUS = NumCpusDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mpic_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mpic_rsp_t out_data_o
);

  localparam int unsigned CpuW     = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned PortCpus = (CPUS < PortLanes) ? CPUS : PortLanes;
  localparam logic [4:0]  NumCpus  = 5'(CPUS);
  localparam logic [3:0]  CpuCode  = 4'(CPUS - 1);
  localparam logic        HasBcast = (CPUS > 1);
  localparam logic [3:0]  PortMask = 4'((1 << PortCpus) - 1);

  logic [15:0] level_q, level_d;
  logic [15:0] pend_q, pend_d;
  logic [15:0] bcast_q, bcast_d;
  logic [15:0] mask_q [CPUS];
  logic [15:0] mask_d [CPUS];
  logic [15:0] force_q [CPUS];
  logic [15:0] force_d [CPUS];
  logic [3:0]  lvl_q [CPUS];
  logic [3:0]  lvl_d [CPUS];
  logic [3:0]  pulse_q, pulse_d;

  logic        out_valid_q;
  mpic_rsp_t   out_q, out_d;
  logic        accept;

  logic [1:0]  page;
  logic [2:0]  word;
  logic [3:0]  idx;
  logic        idx_ok;
  logic [CpuW-1:0] sel;
  logic [15:0] wdat;
  logic [15:0] keep;
  logic        is_rd;
  logic        is_wr;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign page   = in_data_i.reg_addr[5:4];
  assign word   = in_data_i.reg_addr[2:0];
  assign idx    = in_data_i.reg_addr[3:0];
  assign idx_ok = {1'b0, idx} < NumCpus;
  assign sel    = idx_ok ? CpuW'(idx) : '0;
  assign wdat   = in_data_i.write_data[15:0] & LineMask;
  assign keep   = {~in_data_i.write_data[31:17], 1'b0};
  assign is_rd  = (in_data_i.req_type == ReqRead);
  assign is_wr  = (in_data_i.req_type == ReqWrite);

  // Priority search on the state before this request.
  always_comb begin
    logic [15:0] reqb;
    logic [3:0]  hi;
    for (int i = 0; i < CPUS; i++) begin
      reqb     = (force_q[i] | pend_q) & mask_q[i];
      hi       = top_line(reqb & level_q & LineMask);
      lvl_d[i] = (hi != 4'd0) ? hi : top_line(reqb & ~level_q & LineMask);
    end
  end

  always_comb begin
    logic [15:0] hit;
    logic [15:0] pend_clr;
    out_d.read_data  = '0;
    out_d.irq_levels = '0;
    out_d.cpu_reset  = pulse_q;
    level_d  = level_q;
    pend_d   = pend_q;
    bcast_d  = bcast_q;
    pulse_d  = '0;
    pend_clr = '0;
    for (int i = 0; i < CPUS; i++) begin
      mask_d[i]  = mask_q[i];
      force_d[i] = force_q[i];
    end
    for (int i = 0; i < PortCpus; i++) begin
      out_d.irq_levels[4*i +: 4] = lvl_q[i];
    end

    if (is_rd) begin
      case (page)
        PageCtrl: begin
          case (word)
            WordLevel:  out_d.read_data = {16'd0, level_q};
            WordPend:   out_d.read_data = {16'd0, pend_q};
            WordForce0: out_d.read_data = {16'd0, force_q[0]};
            WordStatus: out_d.read_data = {CpuCode, HasBcast, 23'd0,
                                           in_data_i.power_down & PortMask};
            WordBcast: begin
              if (HasBcast) begin
                out_d.read_data = {16'd0, bcast_q};
              end else begin
                out_d.read_data = {CpuCode, HasBcast, 23'd0,
                                   in_data_i.power_down & PortMask};
              end
            end
            default: out_d.read_data = '0;
          endcase
        end
        PageMask:  out_d.read_data = idx_ok ? {16'd0, mask_q[sel]} : '0;
        PageForce: out_d.read_data = idx_ok ? {16'd0, force_q[sel]} : '0;
        default:   out_d.read_data = '0;
      endcase
    end

    if (is_wr) begin
      case (page)
        PageCtrl: begin
          case (word)
            WordLevel:  level_d    = wdat;
            WordPend:   pend_d     = wdat;
            WordForce0: force_d[0] = wdat;
            WordClear:  pend_d     = pend_q & ~in_data_i.write_data[15:0] & LineMask;
            WordStatus: pulse_d    = in_data_i.write_data[3:0] & PortMask;
            WordBcast: begin
              if (HasBcast) begin
                bcast_d = wdat;
              end
            end
            default: pulse_d = '0;
          endcase
        end
        PageMask: begin
          for (int i = 0; i < CPUS; i++) begin
            if (idx_ok && (sel == CpuW'(i))) begin
              mask_d[i] = wdat;
            end
          end
        end
        PageForce: begin
          for (int i = 0; i < CPUS; i++) begin
            if (idx_ok && (sel == CpuW'(i))) begin
              force_d[i] = (force_q[i] | wdat) & keep;
            end
          end
        end
        default: pulse_d = '0;
      endcase
    end

    // Route new lines to pending or to every CPU's force register.
    pend_d = pend_d | (in_data_i.irq_lines & ~bcast_q & LineMask);
    for (int i = 0; i < CPUS; i++) begin
      force_d[i] = force_d[i] | (in_data_i.irq_lines & bcast_q & LineMask);
    end

    for (int i = 0; i < PortCpus; i++) begin
      hit = (16'd1 << in_data_i.ack_levels[4*i +: 4]) & LineMask;
      if (in_data_i.ack_valid[i]) begin
        force_d[i] = force_d[i] & ~hit;
        pend_clr   = pend_clr | (~force_q[i] & hit);
      end
    end
    pend_d = pend_d & ~pend_clr;

    if (in_data_i.clear_all) begin
      pend_d  = '0;
      bcast_d = '0;
      for (int i = 0; i < CPUS; i++) begin
        mask_d[i]  = '0;
        force_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      pend_q  <= '0;
      bcast_q <= '0;
      pulse_q <= '0;
      for (int i = 0; i < CPUS; i++) begin
        mask_q[i]  <= '0;
        force_q[i] <= '0;
        lvl_q[i]   <= '0;
      end
    end else if (accept) begin
      level_q <= level_d;
      pend_q  <= pend_d;
      bcast_q <= bcast_d;
      pulse_q <= pulse_d;
      for (int i = 0; i < CPUS; i++) begin
        mask_q[i]  <= mask_d[i];
        force_q[i] <= force_d[i];
        lvl_q[i]   <= lvl_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  a_pulse_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !(is_wr && page == PageCtrl && word == WordStatus) |=> pulse_q == 4'd0)
    else $error("cpu reset pulse outlived its request");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.clear_all |=> pend_q == 16'd0 && bcast_q == 16'd0)
    else $error("clear did not empty pending and broadcast");

  a_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[0] == 1'b0 && level_q[0] == 1'b0 && bcast_q[0] == 1'b0)
    else $error("line zero entered a register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && !accept)
    else $error("input stalled with empty output register");

endmodule
